>>> hdl/bph_pkg.sv
// bph_pkg: shared widths, register indexes, reset values and the result record
// for the band projection hash block. No dependencies.
package bph_pkg;

	// Fixed field widths
	localparam int CFG_W  = 10;
	localparam int LVL_W  = 8;
	localparam int PIX_W  = 8;
	localparam int IDX_W  = 9;
	localparam int CNT_W  = 16;   // column counter width, wraps like the 16-bit original
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	// Output queue geometry
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PW    = 2;
	localparam int OQ_CW    = 3;

	// Register reset values
	localparam logic [CFG_W-1:0] RST_WIDTH     = 10'd320;
	localparam logic [CFG_W-1:0] RST_HEIGHT    = 10'd180;
	localparam logic [CFG_W-1:0] RST_ROW_BANDS = 10'd36;
	localparam logic [CFG_W-1:0] RST_COL_BANDS = 10'd64;
	localparam logic [LVL_W-1:0] RST_LEVEL     = 8'd100;

	// Register map, word index = paddr[4:2]
	typedef enum logic [2:0] {
		REG_WIDTH     = 3'd0,
		REG_HEIGHT    = 3'd1,
		REG_ROW_BANDS = 3'd2,
		REG_COL_BANDS = 3'd3,
		REG_LEVEL     = 3'd4
	} reg_idx_t;

	// Result kinds
	localparam logic KIND_ROW = 1'b0;
	localparam logic KIND_COL = 1'b1;

	typedef struct packed {
		logic             hash_bit;
		logic             bit_kind;
		logic [IDX_W-1:0] band_index;
		logic             last;
	} result_t;

endpackage

>>> hdl/bph_div.sv
// bph_div: shared restoring divider that derives the row and column band sizes
// from the frame size and band counts, one quotient bit per cycle. Uses bph_pkg.
module bph_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bph_pkg::CFG_W-1:0] height,
	input  logic [bph_pkg::CFG_W-1:0] row_bands,
	input  logic [bph_pkg::CFG_W-1:0] width,
	input  logic [bph_pkg::CFG_W-1:0] col_bands,
	output logic                      busy,
	output logic [bph_pkg::CFG_W-1:0] row_div,
	output logic [bph_pkg::CFG_W-1:0] col_div
);
	import bph_pkg::*;

	localparam int SW = $clog2(CFG_W);

	logic             active_q;
	logic             phase_q;     // 0: row bands, 1: column bands
	logic [SW-1:0]    step_q;
	logic [CFG_W-1:0] num_q;
	logic [CFG_W-1:0] den_q;
	logic [CFG_W-1:0] rem_q;
	logic [CFG_W-1:0] quo_q;
	logic [CFG_W-1:0] row_div_q;
	logic [CFG_W-1:0] col_div_q;

	logic [CFG_W:0]   trial;
	logic             ge;
	logic [CFG_W-1:0] rem_next;
	logic [CFG_W-1:0] quo_next;
	logic [CFG_W-1:0] quo_fix;
	logic [CFG_W-1:0] row_den;
	logic [CFG_W-1:0] col_den;

	// Zero band count acts as one
	assign row_den = (row_bands == '0) ? CFG_W'(1) : row_bands;
	assign col_den = (col_bands == '0) ? CFG_W'(1) : col_bands;

	// One restoring step
	always_comb begin
		trial    = {rem_q, num_q[CFG_W-1]};
		ge       = (trial >= {1'b0, den_q});
		rem_next = ge ? CFG_W'(trial - {1'b0, den_q}) : trial[CFG_W-1:0];
		quo_next = {quo_q[CFG_W-2:0], ge};
		quo_fix  = (quo_next == '0) ? CFG_W'(1) : quo_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			phase_q   <= 1'b0;
			step_q    <= '0;
			row_div_q <= CFG_W'(1);
			col_div_q <= CFG_W'(1);
		end else if (start) begin
			active_q <= 1'b1;
			phase_q  <= 1'b0;
			step_q   <= '0;
			num_q    <= height;
			den_q    <= row_den;
			rem_q    <= '0;
			quo_q    <= '0;
		end else if (active_q) begin
			if (step_q == SW'(CFG_W - 1)) begin
				if (!phase_q) begin
					row_div_q <= quo_fix;
					phase_q   <= 1'b1;
					step_q    <= '0;
					num_q     <= width;
					den_q     <= col_den;
					rem_q     <= '0;
					quo_q     <= '0;
				end else begin
					col_div_q <= quo_fix;
					active_q  <= 1'b0;
				end
			end else begin
				step_q <= step_q + SW'(1);
				num_q  <= {num_q[CFG_W-2:0], 1'b0};
				rem_q  <= rem_next;
				quo_q  <= quo_next;
			end
		end
	end

	assign busy    = active_q | start;
	assign row_div = row_div_q;
	assign col_div = col_div_q;

endmodule

>>> hdl/bph_colmem.sv
// bph_colmem: per-column bright-count memory, one read and one write port, read
// data registered, write-to-read bypass, zeroing sweep after reset. Uses bph_pkg.
module bph_colmem #(
	parameter  int DEPTH = 512,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [bph_pkg::CNT_W-1:0] rd_data,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [bph_pkg::CNT_W-1:0] wr_data,
	output logic                      clr_busy
);
	import bph_pkg::*;

	logic [CNT_W-1:0] mem [DEPTH];
	logic [CNT_W-1:0] rd_data_q;
	logic             clr_active_q;
	logic [AW-1:0]    clr_addr_q;

	// Zeroing sweep, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_active_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	// Write port
	always_ff @(posedge clk) begin
		if (clr_active_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; a same-cycle write to the same column wins
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data  = rd_data_q;
	assign clr_busy = clr_active_q;

	a_no_access_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> (!rd_en && !wr_en))
		else $error("column memory accessed during zeroing sweep");

endmodule

>>> hdl/bph_outq.sv
// bph_outq: four-entry result queue, up to two pushes and one pop per cycle,
// drives the output channel. Uses bph_pkg.
module bph_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_a,
	input  logic             push_b,
	input  bph_pkg::result_t entry_a,
	input  bph_pkg::result_t entry_b,
	output logic             room2,
	output logic             out_valid,
	input  logic             out_stall,
	output bph_pkg::result_t head
);
	import bph_pkg::*;

	result_t          slots [OQ_DEPTH];
	logic [OQ_PW-1:0] wr_ptr_q;
	logic [OQ_PW-1:0] rd_ptr_q;
	logic [OQ_CW-1:0] count_q;
	logic             pop;
	logic [OQ_CW-1:0] n_push;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid & ~out_stall;
	assign room2     = (count_q <= OQ_CW'(OQ_DEPTH - 2));
	assign n_push    = OQ_CW'(push_a) + OQ_CW'(push_b);
	assign head      = slots[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_PW'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OQ_PW'(1);
			end
			count_q <= count_q + n_push - OQ_CW'(pop);
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push_a) begin
			slots[wr_ptr_q] <= entry_a;
		end
		if (push_b) begin
			slots[wr_ptr_q + OQ_PW'(1)] <= entry_b;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push_a || push_b) |-> (count_q <= OQ_CW'(OQ_DEPTH - 2)))
		else $error("result queue pushed without room for two beats");

	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push_b |-> push_a)
		else $error("second result pushed without the first");

endmodule

>>> hdl/band_projection_hash_top.sv
// band_projection_hash_top: pixel stream in, row and column band bits out.
// Uses bph_pkg, bph_div, bph_colmem, bph_outq.
//
// Pixels arrive in raster order on in_valid/in_stall/pixel; one beat per pixel.
// Each pixel may produce zero, one or two result beats on out_valid/out_stall
// (hash_bit, bit_kind, band_index, last); a row bit comes before a column bit.
// Throughput is one pixel per cycle unless the division, the zeroing sweep or
// the result queue stalls the input; it is set by a single read-modify-write of the
// column-count memory per pixel: the read is issued at acceptance, the update
// is written back as the pixel leaves stage 1, with a bypass for the same column.
// A pixel is registered into stage 1, then its results into a four-entry queue,
// where they wait to be taken; when the queue holds more than two beats while a
// pixel waits in stage 1, in_stall rises. After reset the column memory is
// zeroed, one entry per cycle, and band sizes are divided out; in_stall stays
// high meanwhile. Each register write restarts the band-size division and
// stalls the input until it is done. The APB port takes writes at any time.
module band_projection_hash_top #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bph_pkg::APB_AW-1:0] paddr,
	input  logic [bph_pkg::APB_DW-1:0] pwdata,
	output logic [bph_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [bph_pkg::PIX_W-1:0]  pixel,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       hash_bit,
	output logic                       bit_kind,
	output logic [bph_pkg::IDX_W-1:0]  band_index,
	output logic                       last
);
	import bph_pkg::*;

	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int YW  = $clog2(MAX_HEIGHT);
	localparam int RW  = $clog2(MAX_WIDTH + 1);
	localparam int MW  = (XW > YW) ? XW : YW;
	localparam int CW  = ((MW > CFG_W) ? MW : CFG_W) + 1;

	// Configuration registers
	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;
	logic [CFG_W-1:0] row_band_count_q;
	logic [CFG_W-1:0] col_band_count_q;
	logic [LVL_W-1:0] bright_level_q;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;
	logic             start_q;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q    <= RST_WIDTH;
			frame_height_q   <= RST_HEIGHT;
			row_band_count_q <= RST_ROW_BANDS;
			col_band_count_q <= RST_COL_BANDS;
			bright_level_q   <= RST_LEVEL;
			start_q          <= 1'b1;
		end else begin
			start_q <= cfg_wr;
			if (cfg_wr) begin
				case (cfg_idx)
					REG_WIDTH:     frame_width_q    <= pwdata[CFG_W-1:0];
					REG_HEIGHT:    frame_height_q   <= pwdata[CFG_W-1:0];
					REG_ROW_BANDS: row_band_count_q <= pwdata[CFG_W-1:0];
					REG_COL_BANDS: col_band_count_q <= pwdata[CFG_W-1:0];
					REG_LEVEL:     bright_level_q   <= pwdata[LVL_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Register readback
	always_comb begin
		case (cfg_idx)
			REG_WIDTH:     prdata = APB_DW'(frame_width_q);
			REG_HEIGHT:    prdata = APB_DW'(frame_height_q);
			REG_ROW_BANDS: prdata = APB_DW'(row_band_count_q);
			REG_COL_BANDS: prdata = APB_DW'(col_band_count_q);
			REG_LEVEL:     prdata = APB_DW'(bright_level_q);
			default:       prdata = '0;
		endcase
	end

	// Clamped frame size
	logic [CFG_W-1:0] w_c;
	logic [CFG_W-1:0] h_c;

	always_comb begin
		if (frame_width_q == '0) begin
			w_c = CFG_W'(1);
		end else if (CW'(frame_width_q) > CW'(MAX_WIDTH)) begin
			w_c = CFG_W'(MAX_WIDTH);
		end else begin
			w_c = frame_width_q;
		end
		if (frame_height_q == '0) begin
			h_c = CFG_W'(1);
		end else if (CW'(frame_height_q) > CW'(MAX_HEIGHT)) begin
			h_c = CFG_W'(MAX_HEIGHT);
		end else begin
			h_c = frame_height_q;
		end
	end

	// Band sizes
	logic             div_busy;
	logic [CFG_W-1:0] row_div;
	logic [CFG_W-1:0] col_div;

	bph_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_q),
		.height    (h_c),
		.row_bands (row_band_count_q),
		.width     (w_c),
		.col_bands (col_band_count_q),
		.busy      (div_busy),
		.row_div   (row_div),
		.col_div   (col_div)
	);

	// Column count memory
	logic             clr_busy;
	logic [CNT_W-1:0] rd_data;
	logic             accept;
	logic             s1_fire;
	logic [XW-1:0]    x_q;
	logic [XW-1:0]    x_s1;
	logic [CNT_W-1:0] cnt;

	bph_colmem #(.DEPTH(MAX_WIDTH)) u_colmem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (x_q),
		.rd_data  (rd_data),
		.wr_en    (s1_fire),
		.wr_addr  (x_s1),
		.wr_data  (cnt),
		.clr_busy (clr_busy)
	);

	// Stage 0: raster position and brightness
	logic          room2;
	logic          s1_valid_q;
	logic [YW-1:0] y_q;
	logic          row_end;
	logic          last_row;
	logic          bright;

	assign in_stall = div_busy | clr_busy | (s1_valid_q & ~room2);
	assign accept   = in_valid & ~in_stall;
	assign s1_fire  = s1_valid_q & room2;
	assign row_end  = (CW'(x_q) + CW'(1)) >= CW'(w_c);
	assign last_row = (CW'(y_q) + CW'(1)) >= CW'(h_c);
	assign bright   = (pixel > bright_level_q);

	logic bright_s1;
	logic row_end_s1;
	logic last_row_s1;
	logic first_row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q        <= '0;
			y_q        <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				if (row_end) begin
					x_q <= '0;
					y_q <= last_row ? '0 : YW'(CW'(y_q) + CW'(1));
				end else begin
					x_q <= XW'(CW'(x_q) + CW'(1));
				end
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1         <= x_q;
			bright_s1    <= bright;
			row_end_s1   <= row_end;
			last_row_s1  <= last_row;
			first_row_s1 <= (y_q == '0);
		end
	end

	// Stage 1: count update and band decisions
	logic [RW-1:0]    row_cnt_q;
	logic             row_flag_q;
	logic             col_flag_q;
	logic [YW-1:0]    row_off_q;
	logic [XW-1:0]    col_off_q;
	logic [IDX_W-1:0] row_num_q;
	logic [IDX_W-1:0] col_num_q;

	logic [CNT_W:0] cnt_sum;   // one spare bit so the compare sees the carry
	logic [RW-1:0]  row_cnt_next;
	logic           row_hit;
	logic           col_hit;
	logic           row_emit;
	logic           col_emit;
	logic           frame_end;
	result_t        row_res;
	result_t        col_res;
	result_t        entry_a;
	result_t        entry_b;
	logic           push_a;
	logic           push_b;

	always_comb begin
		cnt_sum = first_row_s1 ? (CNT_W+1)'(bright_s1) :
			((CNT_W+1)'(rd_data) + (CNT_W+1)'(bright_s1));
		cnt = cnt_sum[CNT_W-1:0];
		row_cnt_next = row_cnt_q + RW'(bright_s1);
		row_hit  = row_flag_q | (CW'(row_cnt_next) > CW'(w_c >> 1));
		col_hit  = col_flag_q | (cnt_sum > (CNT_W+1)'(h_c >> 1));
		row_emit = row_end_s1 &
			(((CW'(row_off_q) + CW'(1)) >= CW'(row_div)) | last_row_s1);
		col_emit = last_row_s1 &
			(((CW'(col_off_q) + CW'(1)) >= CW'(col_div)) | row_end_s1);
		frame_end = row_end_s1 & last_row_s1;

		row_res.hash_bit   = row_hit;
		row_res.bit_kind   = KIND_ROW;
		row_res.band_index = row_num_q;
		row_res.last       = ~col_emit;
		col_res.hash_bit   = col_hit;
		col_res.bit_kind   = KIND_COL;
		col_res.band_index = col_num_q;
		col_res.last       = 1'b1;

		entry_a = row_emit ? row_res : col_res;
		entry_b = col_res;
		push_a  = s1_fire & (row_emit | col_emit);
		push_b  = s1_fire & row_emit & col_emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q  <= '0;
			row_flag_q <= 1'b0;
			col_flag_q <= 1'b0;
			row_off_q  <= '0;
			col_off_q  <= '0;
			row_num_q  <= '0;
			col_num_q  <= '0;
		end else if (s1_fire) begin
			row_cnt_q <= row_end_s1 ? '0 : row_cnt_next;
			if (frame_end) begin
				row_flag_q <= 1'b0;
				col_flag_q <= 1'b0;
				row_off_q  <= '0;
				col_off_q  <= '0;
				row_num_q  <= '0;
				col_num_q  <= '0;
			end else begin
				// Row band bookkeeping at each row end
				if (row_end_s1) begin
					if (row_emit) begin
						row_flag_q <= 1'b0;
						row_off_q  <= '0;
						row_num_q  <= row_num_q + IDX_W'(1);
					end else begin
						row_flag_q <= row_hit;
						row_off_q  <= YW'(CW'(row_off_q) + CW'(1));
					end
				end
				// Column band bookkeeping along the last row
				if (last_row_s1) begin
					if (col_emit) begin
						col_flag_q <= 1'b0;
						col_off_q  <= '0;
						col_num_q  <= col_num_q + IDX_W'(1);
					end else begin
						col_flag_q <= col_hit;
						col_off_q  <= XW'(CW'(col_off_q) + CW'(1));
					end
				end
			end
		end
	end

	// Result queue and output channel
	result_t head;

	bph_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_a    (push_a),
		.push_b    (push_b),
		.entry_a   (entry_a),
		.entry_b   (entry_b),
		.room2     (room2),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign hash_bit   = head.hash_bit;
	assign bit_kind   = head.bit_kind;
	assign band_index = head.band_index;
	assign last       = head.last;

	a_frame_end_row: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && frame_end) |-> row_emit)
		else $error("frame end without a row band beat");

	a_frame_end_col: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && frame_end) |-> col_emit)
		else $error("frame end without a column band beat");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && frame_end) |=> (row_num_q == '0 && col_num_q == '0 && row_cnt_q == '0))
		else $error("band numbering not restarted after frame end");

endmodule
